// ----- hw/rtl/gpm_pkg.sv -----
package gpm_pkg;

    localparam logic [15:0] BASE_OFF        = 16'hFFFF;
    localparam logic [15:0] BASE_MAX        = 16'd65496;
    localparam logic [6:0]  DEAD_ZONE_RESET = 7'd32;

    localparam logic [3:0]  TYPE_ABSENT = 4'd0;
    localparam logic [3:0]  TYPE_ANALOG = 4'd3;

    localparam logic        REG_RECORD_BASE = 1'b0;
    localparam logic        REG_DEAD_ZONE   = 1'b1;

    localparam logic [7:0]  AXIS_CENTRE = 8'h80;
    localparam logic [7:0]  AXIS_NEG    = 8'h80;
    localparam logic [7:0]  AXIS_POS    = 8'h7F;
    localparam logic [7:0]  TRIG_FULL   = 8'hFF;
    localparam logic [7:0]  CONNECTED   = 8'h80;

    localparam logic [3:0]  DIR_UP    = 4'b0001;
    localparam logic [3:0]  DIR_DOWN  = 4'b0010;
    localparam logic [3:0]  DIR_LEFT  = 4'b0100;
    localparam logic [3:0]  DIR_RIGHT = 4'b1000;

    typedef struct packed {
        logic [15:0] record_base;
        logic [6:0]  dead_zone;
    } cfg_t;

    typedef struct packed {
        logic [15:0] trigger_word;
        logic [31:0] stick_word;
        logic [31:0] button_word;
    } poll_t;

    typedef struct packed {
        logic [7:0] right_trigger;
        logic [7:0] left_trigger;
        logic [7:0] right_y;
        logic [7:0] right_x;
        logic [7:0] left_y;
        logic [7:0] left_x;
        logic [7:0] buttons_b;
        logic [7:0] buttons_a;
        logic [7:0] stick_dirs;
        logic [7:0] status_dpad;
    } record_t;

    function automatic logic [7:0] axis_mag(input logic [7:0] b);
        return b[7] ? (~b + 8'd1) : b;
    endfunction

    function automatic logic [3:0] dir_bits(input logic [7:0] x, input logic [7:0] y,
                                            input logic [6:0] dz);
        logic [7:0] ax;
        logic [7:0] ay;
        logic [7:0] dzw;
        logic [3:0] bits;
        ax   = axis_mag(x);
        ay   = axis_mag(y);
        dzw  = {1'b0, dz};
        bits = 4'd0;
        if (ax > dzw || ay > dzw) begin
            if (ax > dzw && ay <= ax) begin
                bits = bits | (x[7] ? DIR_LEFT : DIR_RIGHT);
            end
            if (ay > dzw && ax <= ay) begin
                bits = bits | (y[7] ? DIR_UP : DIR_DOWN);
            end
        end
        return bits;
    endfunction

endpackage

// ----- hw/rtl/gpm_cfg.sv -----
module gpm_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output gpm_pkg::cfg_t      cfg
);

    logic [15:0] base_reg;
    logic [15:0] base_next;
    logic [6:0]  dz_reg;
    logic [6:0]  dz_next;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_comb begin
        base_next = base_reg;
        dz_next   = dz_reg;
        if (wr_en) begin
            unique case (reg_sel)
                gpm_pkg::REG_RECORD_BASE: begin
                    if (pwdata[15:0] == gpm_pkg::BASE_OFF ||
                        pwdata[15:0] <= gpm_pkg::BASE_MAX) begin
                        base_next = pwdata[15:0];
                    end
                end
                gpm_pkg::REG_DEAD_ZONE: begin
                    dz_next = pwdata[6:0];
                end
                default: begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= gpm_pkg::BASE_OFF;
            dz_reg   <= gpm_pkg::DEAD_ZONE_RESET;
        end else begin
            base_reg <= base_next;
            dz_reg   <= dz_next;
        end
    end

    always_comb begin
        unique case (reg_sel)
            gpm_pkg::REG_RECORD_BASE: prdata = {16'd0, base_reg};
            gpm_pkg::REG_DEAD_ZONE:   prdata = {25'd0, dz_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.record_base = base_reg;
    assign cfg.dead_zone   = dz_reg;

    a_base_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg == gpm_pkg::BASE_OFF || base_reg <= gpm_pkg::BASE_MAX)
        else $error("record base holds a rejected value");

endmodule

// ----- hw/rtl/gpm_map.sv -----
module gpm_map (
    input  gpm_pkg::poll_t   poll,
    input  logic [6:0]       dead_zone,
    output gpm_pkg::record_t rec
);

    logic [31:0] key;
    logic [3:0]  ctype;
    logic [7:0]  lx;
    logic [7:0]  ly;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic [7:0]  lt_raw;
    logic [7:0]  rt_raw;
    logic [7:0]  lt;
    logic [7:0]  rt;
    logic [7:0]  btn_b;
    logic [7:0]  status;

    assign key   = poll.button_word;
    assign ctype = key[31:28];

    always_comb begin
        if (ctype == gpm_pkg::TYPE_ANALOG) begin
            lx     = poll.stick_word[7:0]   ^ gpm_pkg::AXIS_CENTRE;
            ly     = poll.stick_word[15:8]  ^ gpm_pkg::AXIS_CENTRE;
            rx     = poll.stick_word[23:16] ^ gpm_pkg::AXIS_CENTRE;
            ry     = poll.stick_word[31:24] ^ gpm_pkg::AXIS_CENTRE;
            lt_raw = poll.trigger_word[7:0];
            rt_raw = poll.trigger_word[15:8];
            status = gpm_pkg::CONNECTED | {4'd0, key[3:0]};
        end else begin
            lx     = key[2] ? gpm_pkg::AXIS_NEG : (key[3] ? gpm_pkg::AXIS_POS : 8'd0);
            ly     = key[0] ? gpm_pkg::AXIS_NEG : (key[1] ? gpm_pkg::AXIS_POS : 8'd0);
            rx     = 8'd0;
            ry     = 8'd0;
            lt_raw = 8'd0;
            rt_raw = 8'd0;
            status = gpm_pkg::CONNECTED;
        end
    end

    always_comb begin
        lt    = (key[10] && lt_raw == 8'd0) ? gpm_pkg::TRIG_FULL : lt_raw;
        rt    = (key[11] && rt_raw == 8'd0) ? gpm_pkg::TRIG_FULL : rt_raw;
        btn_b = {1'b0, key[13:12], 1'b0, key[15:14], key[11:10]};
        btn_b[0] = btn_b[0] | (lt > {1'b0, dead_zone});
        btn_b[1] = btn_b[1] | (rt > {1'b0, dead_zone});
    end

    always_comb begin
        if (ctype == gpm_pkg::TYPE_ABSENT) begin
            rec = '0;
        end else begin
            rec.status_dpad   = status;
            rec.stick_dirs    = {gpm_pkg::dir_bits(rx, ry, dead_zone),
                                 gpm_pkg::dir_bits(lx, ly, dead_zone)};
            rec.buttons_a     = {key[9:8], 1'b0, key[7:6], 1'b0, key[5:4]};
            rec.buttons_b     = btn_b;
            rec.left_x        = lx;
            rec.left_y        = ly;
            rec.right_x       = rx;
            rec.right_y       = ry;
            rec.left_trigger  = lt;
            rec.right_trigger = rt;
        end
    end

endmodule

// ----- hw/rtl/gamepad_report_mapper.sv -----
// An accepted poll passes through the input register and then the result register, whose
// valid bit drives m_tvalid. Throughput: one poll per cycle while the result register is
// empty or its result is being taken; the input register also loads while it is empty.
// No result is produced for a poll that enters the result register while the record base
// is 65535. Reset (synchronous, active low) empties both registers and sets the record
// base to 65535 and the deadzone to 32.
module gamepad_report_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // button_word [31:0], stick_word [63:32], trigger_word [79:64]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // record_address [15:0], status_dpad [23:16], stick_dirs [31:24], buttons_a [39:32],
    // buttons_b [47:40], left_x [55:48], left_y [63:56], right_x [71:64], right_y [79:72],
    // left_trigger [87:80], right_trigger [95:88]
    output logic [95:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gpm_pkg::cfg_t    cfg;
    gpm_pkg::record_t rec;

    logic             in_valid_reg;
    logic             in_valid_next;
    gpm_pkg::poll_t   in_reg;
    gpm_pkg::poll_t   in_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      out_addr_reg;
    logic [15:0]      out_addr_next;
    gpm_pkg::record_t out_rec_reg;
    gpm_pkg::record_t out_rec_next;
    logic             load_out;
    logic             adv_in;

    gpm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gpm_map u_map (
        .poll      (in_reg),
        .dead_zone (cfg.dead_zone),
        .rec       (rec)
    );

    assign load_out = !out_valid_reg || m_tready;
    assign adv_in   = in_valid_reg && load_out;
    assign s_tready = !in_valid_reg || load_out;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_next        = in_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_rec_next   = out_rec_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_next       = s_tdata;
        end
        if (load_out) begin
            out_valid_next = in_valid_reg && (cfg.record_base != gpm_pkg::BASE_OFF);
            out_addr_next  = cfg.record_base;
            out_rec_next   = rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_reg       <= in_next;
        out_addr_reg <= out_addr_next;
        out_rec_reg  <= out_rec_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rec_reg, out_addr_reg};

    a_addr_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] != gpm_pkg::BASE_OFF)
        else $error("result carries the disabling base address");

    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[23]) |-> m_tdata[95:16] == 80'd0)
        else $error("disconnected record is not all zero");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_valid_reg) |-> adv_in)
        else $error("poll accepted over a held poll");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv_in && cfg.record_base != gpm_pkg::BASE_OFF) |=> m_tvalid)
        else $error("poll moved on without producing its result");

endmodule
